/* rtl/core/base_n_text_to_integer_top_defines.svh */
// Assertion macros used by the top-level RTL file, which carries the checks.
`ifndef BASE_N_TEXT_TO_INTEGER_TOP_DEFINES_SVH
`define BASE_N_TEXT_TO_INTEGER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BNTI_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BNTI_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/bnti_pkg.sv */
package bnti_pkg;

  localparam int MAX_BASE_DEFAULT = 16;
  localparam int MAX_SYMBOLS      = 16;
  localparam int SYMS_PER_WORD    = 8;

  localparam int CH_W        = 8;
  localparam int VALUE_W     = 32;
  localparam int BASE_SIZE_W = 5;
  localparam int ALPHA_W     = SYMS_PER_WORD * CH_W;
  localparam int DIGIT_W     = 4;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_SIZE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET_HIGH = 2'd2;

  localparam logic [CH_W-1:0] CH_NUL   = 8'd0;
  localparam logic [CH_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CH_W-1:0] CH_CR    = 8'd13;
  localparam logic [CH_W-1:0] CH_SPACE = 8'd32;
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;

  typedef logic [MAX_SYMBOLS-1:0][CH_W-1:0] alphabet_t;

  typedef struct packed {
    logic               hit;
    logic [DIGIT_W-1:0] index;
  } digit_t;

  function automatic logic is_space(input logic [CH_W-1:0] c);
    return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
  endfunction

  function automatic logic is_sign(input logic [CH_W-1:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS);
  endfunction

endpackage

/* rtl/core/bnti_base_check.sv */
module bnti_base_check #(
  parameter int MAX_BASE = bnti_pkg::MAX_BASE_DEFAULT
) (
  input  logic [bnti_pkg::BASE_SIZE_W-1:0] base_size,
  input  bnti_pkg::alphabet_t              symbols,
  output logic                             base_ok
);

  always_comb begin
    logic bad;
    bad = (base_size < bnti_pkg::BASE_SIZE_W'(2)) ||
          (base_size > bnti_pkg::BASE_SIZE_W'(MAX_BASE));
    for (int i = 0; i < MAX_BASE; i++) begin
      if (bnti_pkg::BASE_SIZE_W'(i) < base_size) begin
        if ((symbols[i] == bnti_pkg::CH_NUL) || bnti_pkg::is_sign(symbols[i]) ||
            bnti_pkg::is_space(symbols[i])) begin
          bad = 1'b1;
        end
        for (int j = 0; j < i; j++) begin
          if (symbols[j] == symbols[i]) begin
            bad = 1'b1;
          end
        end
      end
    end
    base_ok = !bad;
  end

endmodule

/* rtl/core/bnti_digit_lookup.sv */
module bnti_digit_lookup #(
  parameter int MAX_BASE = bnti_pkg::MAX_BASE_DEFAULT
) (
  input  logic [bnti_pkg::CH_W-1:0]        ch,
  input  logic [bnti_pkg::BASE_SIZE_W-1:0] base_size,
  input  bnti_pkg::alphabet_t              symbols,
  output bnti_pkg::digit_t                 digit
);

  // The lowest matching position wins, so the loop runs from the top down.
  always_comb begin
    digit = '0;
    for (int i = MAX_BASE - 1; i >= 0; i--) begin
      if ((bnti_pkg::BASE_SIZE_W'(i) < base_size) && (symbols[i] == ch)) begin
        digit.hit   = 1'b1;
        digit.index = bnti_pkg::DIGIT_W'(i);
      end
    end
  end

endmodule

/* rtl/core/base_n_text_to_integer_top.sv */
// Streaming text-to-integer parser with a programmable digit alphabet. One character enters
// per request on the slave side, and a new character can be taken every clock cycle while
// the input does not stall; each character is registered, then resolved by an alphabet
// compare and a multiply-add into the running value, so the rate is one character per cycle,
// set by that multiply-add loop. A string starts with a character whose tuser bit is set;
// leading whitespace is skipped, a run of '+' and '-' sets the sign, and digits accumulate
// modulo 2^32. The first character that is neither, including a zero byte, makes one signed
// result valid on the master side through the input register and the output register; later
// characters are dropped until the next start. The input stalls only while the input
// register holds a character and a result waits on the master side. An invalid alphabet
// ends an active string with a result of zero. Configuration must be written through the
// plain write port only while no string is active; the block itself does not enforce this.
`include "base_n_text_to_integer_top_defines.svh"

module base_n_text_to_integer_top #(
  parameter int MAX_BASE = bnti_pkg::MAX_BASE_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [bnti_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bnti_pkg::ALPHA_W-1:0]   cfg_wdata,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [bnti_pkg::CH_W-1:0]      s_tdata,   // [7:0] ch
  input  logic                           s_tuser,   // [0] start_req
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [bnti_pkg::VALUE_W-1:0]   m_tdata    // [31:0] value
);

  localparam logic [1:0] PH_DONE  = 2'd0;
  localparam logic [1:0] PH_SPACE = 2'd1;
  localparam logic [1:0] PH_SIGN  = 2'd2;
  localparam logic [1:0] PH_DIGIT = 2'd3;

  logic [bnti_pkg::BASE_SIZE_W-1:0] base_size;
  logic [bnti_pkg::ALPHA_W-1:0]     alphabet_low;
  logic [bnti_pkg::ALPHA_W-1:0]     alphabet_high;
  bnti_pkg::alphabet_t              symbols;

  logic                      s1_valid;
  logic [bnti_pkg::CH_W-1:0] s1_ch;
  logic                      s1_start;
  logic                      s1_fire;
  logic                      out_free;

  logic [1:0]                   phase;
  logic [1:0]                   phase_next;
  logic                         negate;
  logic                         negate_next;
  logic [bnti_pkg::VALUE_W-1:0] accum;
  logic [bnti_pkg::VALUE_W-1:0] accum_next;
  logic                         emit;
  logic [bnti_pkg::VALUE_W-1:0] emit_value;

  logic             base_ok;
  bnti_pkg::digit_t digit;

  assign symbols = {alphabet_high, alphabet_low};

  always_ff @(posedge clk) begin
    if (rst) begin
      base_size     <= '0;
      alphabet_low  <= '0;
      alphabet_high <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        bnti_pkg::CFG_BASE_SIZE:     base_size     <= cfg_wdata[bnti_pkg::BASE_SIZE_W-1:0];
        bnti_pkg::CFG_ALPHABET_LOW:  alphabet_low  <= cfg_wdata;
        bnti_pkg::CFG_ALPHABET_HIGH: alphabet_high <= cfg_wdata;
        default: ;
      endcase
    end
  end

  bnti_base_check #(
    .MAX_BASE(MAX_BASE)
  ) u_base_check (
    .base_size(base_size),
    .symbols  (symbols),
    .base_ok  (base_ok)
  );

  bnti_digit_lookup #(
    .MAX_BASE(MAX_BASE)
  ) u_digit_lookup (
    .ch       (s1_ch),
    .base_size(base_size),
    .symbols  (symbols),
    .digit    (digit)
  );

  assign out_free = !m_tvalid || m_tready;
  assign s1_fire  = s1_valid && out_free;
  assign s_tready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      s1_ch    <= s_tdata;
      s1_start <= s_tuser;
    end
  end

  always_comb begin
    logic [1:0]                   ph;
    logic                         neg;
    logic [bnti_pkg::VALUE_W-1:0] acc;
    ph  = s1_start ? PH_SPACE : phase;
    neg = s1_start ? 1'b0 : negate;
    acc = s1_start ? '0 : accum;
    phase_next  = ph;
    negate_next = neg;
    accum_next  = acc;
    emit        = 1'b0;
    emit_value  = '0;
    if (ph != PH_DONE) begin
      if (!base_ok) begin
        phase_next = PH_DONE;
        emit       = 1'b1;
      end else if ((ph == PH_SPACE) && bnti_pkg::is_space(s1_ch)) begin
        phase_next = PH_SPACE;
      end else if (((ph == PH_SPACE) || (ph == PH_SIGN)) && bnti_pkg::is_sign(s1_ch)) begin
        phase_next  = PH_SIGN;
        negate_next = neg ^ (s1_ch == bnti_pkg::CH_MINUS);
      end else if (digit.hit) begin
        phase_next = PH_DIGIT;
        accum_next = acc * {{(bnti_pkg::VALUE_W-bnti_pkg::BASE_SIZE_W){1'b0}}, base_size}
                     + {{(bnti_pkg::VALUE_W-bnti_pkg::DIGIT_W){1'b0}}, digit.index};
      end else begin
        phase_next = PH_DONE;
        emit       = 1'b1;
        emit_value = neg ? ('0 - acc) : acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_DONE;
      negate <= 1'b0;
      accum  <= '0;
    end else if (s1_fire) begin
      phase  <= phase_next;
      negate <= negate_next;
      accum  <= accum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_fire && emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && emit) begin
      m_tdata <= emit_value;
    end
  end

  `BNTI_ASSERT_NEXT(a_bad_base_gives_zero, clk, rst, s1_fire && !base_ok && (s1_start || phase != PH_DONE), m_tvalid && (m_tdata == '0), "invalid alphabet did not end the string with zero")
  `BNTI_ASSERT_NEXT(a_result_ends_string, clk, rst, s1_fire && emit, phase == PH_DONE, "string still active after its result")
  `BNTI_ASSERT_NEXT(a_stage_holds, clk, rst, s1_valid && !s1_fire, s1_valid && $stable(s1_ch) && $stable(s1_start), "held character lost while output stalled")

endmodule

/* tb/sv/base_n_text_to_integer_top_tb.sv */
`timescale 1ns / 1ps

module base_n_text_to_integer_top_tb;
  import bnti_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 300;
  localparam int SETTLE_CYCLES  = 8;
  localparam int PHASE_ITEMS    = 110;
  localparam int NUM_PHASES     = 10;

  typedef enum logic [1:0] {P_DONE, P_SPACE, P_SIGN, P_DIGIT} parse_phase_e;
  typedef enum logic [1:0] {ALPHA_ANY, ALPHA_PAIR, ALPHA_FULL, ALPHA_BAD} alpha_kind_e;

  typedef struct {
    logic [CH_W-1:0]    c;
    bit                 st;
    bit                 typed;
    logic [VALUE_W-1:0] want;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_BASE_SIZE;
  logic [ALPHA_W-1:0]   cfg_wdata = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [CH_W-1:0]      s_tdata = '0;
  logic                 s_tuser = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [VALUE_W-1:0]   m_tdata;

  base_n_text_to_integer_top uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the parser state and the alphabet registers.
  parse_phase_e         phase_q = P_DONE;
  logic                 neg_q = 1'b0;
  logic [VALUE_W-1:0]   acc_q = '0;
  logic [BASE_SIZE_W-1:0] radix = '0;
  logic [ALPHA_W-1:0]   alpha_lo = '0;
  logic [ALPHA_W-1:0]   alpha_hi = '0;

  logic [VALUE_W-1:0]   expected_values[$];
  logic [VALUE_W-1:0]   want_value;
  int                   mismatches = 0;
  int                   idle_cycles = 0;
  int                   items_sent = 0;
  bit                   calm = 1'b0;
  bit                   long_hold = 1'b0;

  stim_row_t directed_rows [23] = '{
    '{"9",      1'b1, 1'b0, 32'd0},
    '{CH_SPACE, 1'b1, 1'b0, 32'd0},
    '{CH_TAB,   1'b0, 1'b0, 32'd0},
    '{CH_CR,    1'b0, 1'b0, 32'd0},
    '{CH_MINUS, 1'b0, 1'b0, 32'd0},
    '{CH_PLUS,  1'b0, 1'b0, 32'd0},
    '{CH_MINUS, 1'b0, 1'b0, 32'd0},
    '{CH_MINUS, 1'b0, 1'b0, 32'd0},
    '{"4",      1'b0, 1'b0, 32'd0},
    '{"2",      1'b0, 1'b0, 32'd0},
    '{CH_NUL,   1'b0, 1'b1, 32'hFFFF_FFD6},
    '{"5",      1'b0, 1'b0, 32'd0},
    '{"2",      1'b1, 1'b0, 32'd0},
    '{"1",      1'b0, 1'b0, 32'd0},
    '{"4",      1'b0, 1'b0, 32'd0},
    '{"7",      1'b0, 1'b0, 32'd0},
    '{"4",      1'b0, 1'b0, 32'd0},
    '{"8",      1'b0, 1'b0, 32'd0},
    '{"3",      1'b0, 1'b0, 32'd0},
    '{"6",      1'b0, 1'b0, 32'd0},
    '{"4",      1'b0, 1'b0, 32'd0},
    '{"8",      1'b0, 1'b0, 32'd0},
    '{8'hFF,    1'b0, 1'b1, 32'h8000_0000}
  };

  function automatic logic [CH_W-1:0] symbol(input int k);
    return (k < SYMS_PER_WORD) ? alpha_lo[CH_W*k +: CH_W] :
                                 alpha_hi[CH_W*(k-SYMS_PER_WORD) +: CH_W];
  endfunction

  function automatic bit is_blank(input logic [CH_W-1:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic bit alphabet_ok();
    logic [CH_W-1:0] s;
    if (radix < 2 || radix > MAX_BASE_DEFAULT) return 1'b0;
    for (int i = 0; i < radix; i++) begin
      s = symbol(i);
      if (s == CH_NUL || s == CH_PLUS || s == CH_MINUS || is_blank(s)) return 1'b0;
      for (int j = 0; j < i; j++)
        if (symbol(j) == s) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic int digit_index(input logic [CH_W-1:0] c);
    for (int i = 0; i < radix && i < MAX_SYMBOLS; i++)
      if (symbol(i) == c) return i;
    return -1;
  endfunction

  // Advances the shadow parser by one character and reports the value it emits, if any.
  task automatic parse_char(input logic [CH_W-1:0] c, input bit st, output bit emit,
                            output logic [VALUE_W-1:0] v);
    int d;
    emit = 1'b0;
    v = '0;
    if (st) begin
      phase_q = P_SPACE;
      neg_q = 1'b0;
      acc_q = '0;
    end
    if (phase_q == P_DONE) return;
    if (!alphabet_ok()) begin
      phase_q = P_DONE;
      emit = 1'b1;
      return;
    end
    if (phase_q == P_SPACE) begin
      if (is_blank(c)) return;
      phase_q = P_SIGN;
    end
    if (phase_q == P_SIGN) begin
      if (c == CH_PLUS || c == CH_MINUS) begin
        if (c == CH_MINUS) neg_q = !neg_q;
        return;
      end
      phase_q = P_DIGIT;
    end
    d = digit_index(c);
    if (d >= 0) begin
      acc_q = acc_q * radix + 32'(d);
      return;
    end
    phase_q = P_DONE;
    emit = 1'b1;
    v = neg_q ? 32'(0 - acc_q) : acc_q;
  endtask

  task automatic send_char(input logic [CH_W-1:0] c, input bit st, input bit typed,
                           input logic [VALUE_W-1:0] tv);
    bit                 emit;
    logic [VALUE_W-1:0] v;
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= c;
    s_tuser <= st;
    do @(posedge clk); while (!s_tready);
    parse_char(c, st, emit, v);
    if (emit || typed) expected_values.push_back(typed ? tv : v);
    items_sent++;
    @(negedge clk);
  endtask

  // Stops offering requests and waits until every expected value has come out.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (expected_values.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_regs(input logic [BASE_SIZE_W-1:0] sz, input logic [ALPHA_W-1:0] lo,
                            input logic [ALPHA_W-1:0] hi);
    logic [ALPHA_W-1:0] sz_word;
    sz_word = {$urandom, $urandom};
    sz_word[BASE_SIZE_W-1:0] = sz;
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_BASE_SIZE;
    cfg_wdata <= sz_word;
    @(posedge clk);
    radix = sz;
    @(negedge clk);
    cfg_index <= CFG_ALPHABET_LOW;
    cfg_wdata <= lo;
    @(posedge clk);
    alpha_lo = lo;
    @(negedge clk);
    cfg_index <= CFG_ALPHABET_HIGH;
    cfg_wdata <= hi;
    @(posedge clk);
    alpha_hi = hi;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [CH_W-1:0] any_blank();
    return $urandom_range(0, 1) ? CH_SPACE : CH_W'($urandom_range(CH_TAB, CH_CR));
  endfunction

  function automatic logic [CH_W-1:0] any_forbidden();
    case ($urandom_range(0, 3))
      0: return CH_NUL;
      1: return any_blank();
      2: return CH_PLUS;
      default: return CH_MINUS;
    endcase
  endfunction

  task automatic pick_alphabet(input alpha_kind_e kind, output logic [BASE_SIZE_W-1:0] sz,
                               output logic [ALPHA_W-1:0] lo, output logic [ALPHA_W-1:0] hi);
    logic [CH_W-1:0] syms [MAX_SYMBOLS];
    logic [CH_W-1:0] c;
    int              n;
    bit              clash;
    case (kind)
      ALPHA_PAIR: n = 2;
      ALPHA_FULL: n = MAX_SYMBOLS;
      default:    n = $urandom_range(2, MAX_SYMBOLS);
    endcase
    for (int k = 0; k < MAX_SYMBOLS; k++) syms[k] = CH_W'($urandom);
    for (int k = 0; k < n; k++) begin
      do begin
        c = CH_W'($urandom_range(1, 255));
        clash = is_blank(c) || c == CH_PLUS || c == CH_MINUS;
        for (int j = 0; j < k; j++)
          if (syms[j] == c) clash = 1'b1;
      end while (clash);
      syms[k] = c;
    end
    sz = BASE_SIZE_W'(n);
    if (kind == ALPHA_PAIR && $urandom_range(0, 1)) begin
      syms[0] = 8'h01;
      syms[1] = 8'hFF;
    end
    if (kind == ALPHA_BAD) begin
      case ($urandom_range(0, 2))
        0: begin
          case ($urandom_range(0, 3))
            0: sz = '0;
            1: sz = 5'd1;
            2: sz = '1;
            default: sz = BASE_SIZE_W'($urandom_range(MAX_BASE_DEFAULT + 1, 31));
          endcase
        end
        1: syms[n-1] = syms[$urandom_range(0, n-2)];
        default: syms[$urandom_range(0, n-1)] = any_forbidden();
      endcase
    end
    for (int k = 0; k < SYMS_PER_WORD; k++) begin
      lo[CH_W*k +: CH_W] = syms[k];
      hi[CH_W*k +: CH_W] = syms[k+SYMS_PER_WORD];
    end
  endtask

  task automatic send_string();
    logic [CH_W-1:0] seq[$];
    int              shape;
    bit              have_digits;
    shape = $urandom_range(0, 9);
    have_digits = (radix >= 2 && radix <= MAX_BASE_DEFAULT);
    if (shape == 0) begin
      repeat ($urandom_range(1, 4)) seq.push_back(CH_W'($urandom));
    end else begin
      repeat ($urandom_range(0, 3)) seq.push_back(any_blank());
      repeat ($urandom_range(0, 3)) seq.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
      repeat ($urandom_range(0, 12))
        seq.push_back(have_digits ? symbol($urandom_range(0, radix - 1)) : CH_W'($urandom));
      if (shape == 1) begin
        if (seq.size() > 1) repeat ($urandom_range(0, seq.size() - 1)) void'(seq.pop_back());
      end else begin
        seq.push_back($urandom_range(0, 1) ? CH_NUL : CH_W'($urandom));
        repeat ($urandom_range(0, 2)) seq.push_back(CH_W'($urandom));
      end
    end
    if (seq.size() == 0) seq.push_back(CH_NUL);
    foreach (seq[i])
      send_char(seq[i], (i == 0) && (shape != 0 || $urandom_range(0, 1)), 1'b0, '0);
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_values.size() == 0) begin
        $error("value: no result expected, actual %0d", $signed(m_tdata));
        mismatches++;
      end else begin
        want_value = expected_values.pop_front();
        if (m_tdata !== want_value) begin
          $error("value: expected %0d, actual %0d", $signed(want_value), $signed(m_tdata));
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_wr_en || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_hold) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  end

  initial begin
    alpha_kind_e            plan [NUM_PHASES];
    logic [BASE_SIZE_W-1:0] sz;
    logic [ALPHA_W-1:0]     lo;
    logic [ALPHA_W-1:0]     hi;
    int                     phase_start;
    plan = '{ALPHA_FULL, ALPHA_PAIR, ALPHA_ANY, ALPHA_BAD, ALPHA_ANY,
             ALPHA_FULL, ALPHA_BAD, ALPHA_PAIR, ALPHA_ANY, ALPHA_FULL};
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Out of reset the alphabet is empty, so a started string ends at once with zero.
    send_char("7", 1'b0, 1'b0, '0);
    send_char("7", 1'b1, 1'b1, 32'd0);
    drain();

    write_regs(5'd10, 64'h3736_3534_3332_3130, 64'hFFFF_FFFF_FFFF_3938);
    foreach (directed_rows[i])
      send_char(directed_rows[i].c, directed_rows[i].st, directed_rows[i].typed,
                directed_rows[i].want);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      calm = (p >= NUM_PHASES - 2);
      pick_alphabet(plan[p], sz, lo, hi);
      write_regs(sz, lo, hi);
      if (p == 2) long_hold = 1'b1;
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) send_string();
      send_char(CH_NUL, 1'b1, 1'b0, '0);
      drain();
    end

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
